>>> sv/sal_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the set-associative LRU cache lookup.
package sal_pkg;

  localparam int unsigned WAYS             = 8;
  localparam int unsigned SETS             = 1024;  // power of two
  localparam int unsigned LINE_OFFSET_BITS = 6;
  localparam int unsigned ADDR_W           = 64;
  localparam int unsigned TAG_LSB          = 16;
  localparam int unsigned TAG_W            = ADDR_W - TAG_LSB;
  localparam int unsigned WAY_W            = $clog2(WAYS);
  localparam int unsigned SET_W            = $clog2(SETS);
  localparam int unsigned RANK_W           = $clog2(WAYS) + 1;
  localparam int unsigned CNT_W            = 64;

  localparam logic signed [RANK_W-1:0] RANK_MRU   = RANK_W'(WAYS - 1);
  localparam logic signed [RANK_W-1:0] RANK_EMPTY = '1;

  typedef enum logic {
    CMD_ACCESS = 1'b0,
    CMD_INVAL  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic                     valid;
    logic signed [RANK_W-1:0] rank;
  } meta_t;

  typedef meta_t [WAYS-1:0]            meta_row_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;

  typedef struct packed {
    logic hit;
    logic better;
  } cmp_res_t;

  localparam int unsigned META_ROW_W = $bits(meta_row_t);
  localparam int unsigned TAG_ROW_W  = $bits(tag_row_t);

  localparam meta_t META_EMPTY = '{valid: 1'b0, rank: RANK_EMPTY};

endpackage

>>> sv/sal_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces for the cache lookup.
interface sal_req_if;
  import sal_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

interface sal_rsp_if;
  import sal_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] way_used;
  logic             evicted_valid;
  logic [TAG_W-1:0] evicted_tag;
  logic [CNT_W-1:0] miss_count;

  modport source (output valid, output hit, output way_used, output evicted_valid,
                  output evicted_tag, output miss_count, input ready);
  modport sink   (input valid, input hit, input way_used, input evicted_valid,
                  input evicted_tag, input miss_count, output ready);
endinterface

>>> sv/sal_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sal_way_cmp.sv
`timescale 1ns / 1ps
// Shared per-way compare unit: tag match and victim rank compare.
module sal_way_cmp (
  input  logic [sal_pkg::TAG_W-1:0]         tag_a_i,
  input  logic [sal_pkg::TAG_W-1:0]         tag_b_i,
  input  sal_pkg::meta_t                    meta_i,
  input  logic signed [sal_pkg::RANK_W-1:0] best_rank_i,
  input  logic                              first_i,
  output sal_pkg::cmp_res_t                 res_o
);
  import sal_pkg::*;

  always_comb begin
    res_o.hit    = meta_i.valid && (tag_a_i == tag_b_i);
    res_o.better = first_i || (meta_i.rank < best_rank_i);
  end

endmodule

>>> sv/sal_rank_upd.sv
`timescale 1ns / 1ps
// LRU rank update of one set: touched way to MRU or empty, higher ranks drop by one.
module sal_rank_upd (
  input  sal_pkg::meta_row_t           meta_row_i,
  input  logic [sal_pkg::WAY_W-1:0]    target_i,
  input  logic                         fill_i,
  output sal_pkg::meta_row_t           meta_row_o
);
  import sal_pkg::*;

  logic signed [RANK_W-1:0] old_rank;

  always_comb begin
    old_rank = meta_row_i[target_i].rank;
    for (int w = 0; w < WAYS; w++) begin
      meta_row_o[w] = meta_row_i[w];
      if (target_i == WAY_W'(w)) begin
        meta_row_o[w].valid = fill_i;
        meta_row_o[w].rank  = fill_i ? RANK_MRU : RANK_EMPTY;
      end else if (meta_row_i[w].rank > old_rank) begin
        meta_row_o[w].rank = meta_row_i[w].rank - RANK_W'(1);
      end
    end
  end

endmodule

>>> sv/set_assoc_lru_cache_lookup.sv
`timescale 1ns / 1ps
// Flow: ST_IDLE accepts a request and reads its set row, ST_SCAN compares the ways, ST_WRITE responds.
// One request at a time; one way per cycle through a shared compare unit.
// The set row is read once and written back at most once per request (read-modify-write).
// Reset: a clearing pass over all SETS rows empties the rank/valid RAM; ready stays low.
// The response register lets a new request in while the previous response waits.
module set_assoc_lru_cache_lookup (
  input  logic       clk_i,
  input  logic       rst_ni,
  sal_req_if.sink    req_i,
  sal_rsp_if.source  rsp_o
);
  import sal_pkg::*;

  state_e                   state_q, state_d;
  logic [WAY_W-1:0]         way_q, way_d;
  logic [SET_W-1:0]         clr_q, clr_d;
  logic [CNT_W-1:0]         miss_q, miss_d;
  logic                     rsp_valid_q, rsp_valid_d;

  cmd_e                     cmd_q, cmd_d;
  logic [TAG_W-1:0]         tag_q, tag_d;
  logic [SET_W-1:0]         set_q, set_d;
  logic                     match_q, match_d;
  logic [WAY_W-1:0]         match_way_q, match_way_d;
  logic signed [RANK_W-1:0] best_rank_q, best_rank_d;
  logic [WAY_W-1:0]         best_way_q, best_way_d;
  logic                     hit_q, hit_d;
  logic [WAY_W-1:0]         way_used_q, way_used_d;
  logic                     ev_valid_q, ev_valid_d;
  logic [TAG_W-1:0]         ev_tag_q, ev_tag_d;
  logic [CNT_W-1:0]         miss_out_q, miss_out_d;

  logic                     req_ready;
  logic                     accept;
  logic                     meta_we, tag_we;
  logic [SET_W-1:0]         waddr;
  logic [META_ROW_W-1:0]    meta_rdata, meta_wdata;
  logic [TAG_ROW_W-1:0]     tag_rdata, tag_wdata;
  meta_row_t                meta_row, meta_new, meta_clear;
  tag_row_t                 tag_row, tag_new;
  cmp_res_t                 cmp_res;
  logic                     is_access, is_miss;
  logic [WAY_W-1:0]         target;

  assign meta_row = meta_row_t'(meta_rdata);
  assign tag_row  = tag_row_t'(tag_rdata);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      meta_clear[w] = META_EMPTY;
    end
  end

  assign req_ready = (state_q == ST_IDLE);
  assign accept    = req_i.valid && req_ready;

  sal_ram #(
    .WIDTH (META_ROW_W),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (waddr),
    .wdata_i (meta_wdata),
    .re_i    (accept),
    .raddr_i (req_i.address[LINE_OFFSET_BITS +: SET_W]),
    .rdata_o (meta_rdata)
  );

  sal_ram #(
    .WIDTH (TAG_ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (set_q),
    .wdata_i (tag_wdata),
    .re_i    (accept),
    .raddr_i (req_i.address[LINE_OFFSET_BITS +: SET_W]),
    .rdata_o (tag_rdata)
  );

  sal_way_cmp u_way_cmp (
    .tag_a_i     (tag_row[way_q]),
    .tag_b_i     (tag_q),
    .meta_i      (meta_row[way_q]),
    .best_rank_i (best_rank_q),
    .first_i     (way_q == '0),
    .res_o       (cmp_res)
  );

  assign is_access = (cmd_q == CMD_ACCESS);
  assign is_miss   = is_access && !match_q;
  assign target    = match_q ? match_way_q : best_way_q;

  sal_rank_upd u_rank_upd (
    .meta_row_i (meta_row),
    .target_i   (target),
    .fill_i     (is_access),
    .meta_row_o (meta_new)
  );

  always_comb begin
    tag_new         = tag_row;
    tag_new[target] = tag_q;
  end

  assign tag_wdata = TAG_ROW_W'(tag_new);

  always_comb begin
    state_d     = state_q;
    way_d       = way_q;
    clr_d       = clr_q;
    miss_d      = miss_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    cmd_d       = cmd_q;
    tag_d       = tag_q;
    set_d       = set_q;
    match_d     = match_q;
    match_way_d = match_way_q;
    best_rank_d = best_rank_q;
    best_way_d  = best_way_q;
    hit_d       = hit_q;
    way_used_d  = way_used_q;
    ev_valid_d  = ev_valid_q;
    ev_tag_d    = ev_tag_q;
    miss_out_d  = miss_out_q;
    meta_we     = 1'b0;
    tag_we      = 1'b0;
    waddr       = set_q;
    meta_wdata  = META_ROW_W'(meta_new);

    unique case (state_q)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        waddr      = clr_q;
        meta_wdata = META_ROW_W'(meta_clear);
        clr_d      = clr_q + SET_W'(1);
        if (clr_q == SET_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_e'(req_i.command);
          tag_d   = req_i.address[TAG_LSB +: TAG_W];
          set_d   = req_i.address[LINE_OFFSET_BITS +: SET_W];
          way_d   = '0;
          match_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_res.hit && !match_q) begin
          match_d     = 1'b1;
          match_way_d = way_q;
        end
        if (cmp_res.better) begin
          best_rank_d = meta_row[way_q].rank;
          best_way_d  = way_q;
        end
        way_d = way_q + WAY_W'(1);
        if (way_q == WAY_W'(WAYS - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          meta_we     = is_access || match_q;
          tag_we      = is_miss;
          miss_d      = is_miss ? miss_q + CNT_W'(1) : miss_q;
          rsp_valid_d = 1'b1;
          hit_d       = match_q;
          way_used_d  = (is_access || match_q) ? target : '0;
          ev_valid_d  = is_miss && meta_row[target].valid;
          ev_tag_d    = (is_miss && meta_row[target].valid) ? tag_row[target] : '0;
          miss_out_d  = is_miss ? miss_q + CNT_W'(1) : miss_q;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      way_q       <= '0;
      clr_q       <= '0;
      miss_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      way_q       <= way_d;
      clr_q       <= clr_d;
      miss_q      <= miss_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    tag_q       <= tag_d;
    set_q       <= set_d;
    match_q     <= match_d;
    match_way_q <= match_way_d;
    best_rank_q <= best_rank_d;
    best_way_q  <= best_way_d;
    hit_q       <= hit_d;
    way_used_q  <= way_used_d;
    ev_valid_q  <= ev_valid_d;
    ev_tag_q    <= ev_tag_d;
    miss_out_q  <= miss_out_d;
  end

  assign req_i.ready         = req_ready;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = hit_q;
  assign rsp_o.way_used      = way_used_q;
  assign rsp_o.evicted_valid = ev_valid_q;
  assign rsp_o.evicted_tag   = ev_tag_q;
  assign rsp_o.miss_count    = miss_out_q;

endmodule

>>> sv/sal_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the cache lookup, bound to the top level.
module sal_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_hit_i,
  input logic [sal_pkg::WAY_W-1:0]   rsp_way_used_i,
  input logic                        rsp_evicted_valid_i,
  input logic [sal_pkg::TAG_W-1:0]   rsp_evicted_tag_i,
  input logic [sal_pkg::CNT_W-1:0]   rsp_miss_count_i
);
  import sal_pkg::*;

  // one request in flight at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i) &&
      $stable(rsp_way_used_i) && $stable(rsp_miss_count_i) && $stable(rsp_evicted_tag_i))
    else $error("stalled response changed");

  a_evict_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_evicted_valid_i && rsp_hit_i))
    else $error("eviction reported on a hit");

  a_evict_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_evicted_valid_i |-> rsp_evicted_tag_i == '0)
    else $error("evicted tag nonzero without eviction");

endmodule

bind set_assoc_lru_cache_lookup sal_chk u_sal_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_hit_i           (rsp_o.hit),
  .rsp_way_used_i      (rsp_o.way_used),
  .rsp_evicted_valid_i (rsp_o.evicted_valid),
  .rsp_evicted_tag_i   (rsp_o.evicted_tag),
  .rsp_miss_count_i    (rsp_o.miss_count)
);
